### sv/rvdec_pkg.sv
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared types and constants of the RV64I instruction decoder pipeline.
// ----------------------------------------------------------------------------
package rvdec_pkg;

  localparam logic [6:0] OP_R      = 7'b0110011;
  localparam logic [6:0] OP_IALU   = 7'b0010011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] F7_ALT    = 7'b0100000;
  localparam logic [5:0] F6_ALT    = 6'b010000;

  typedef enum logic [3:0] {
    FMT_NONE   = 4'd0,
    FMT_R      = 4'd1,
    FMT_IALU   = 4'd2,
    FMT_LOAD   = 4'd3,
    FMT_JALR   = 4'd4,
    FMT_STORE  = 4'd5,
    FMT_BRANCH = 4'd6,
    FMT_JAL    = 4'd7,
    FMT_LUI    = 4'd8,
    FMT_AUIPC  = 4'd9
  } fmt_e;

  typedef enum logic [2:0] {
    FORM_REG3   = 3'd0,
    FORM_RRI    = 3'd1,
    FORM_OFFSET = 3'd2,
    FORM_BRANCH = 3'd3,
    FORM_JUMP   = 3'd4,
    FORM_UPPER  = 3'd5
  } form_e;

  typedef enum logic [2:0] {
    IMM_ZERO  = 3'd0,
    IMM_I     = 3'd1,
    IMM_SHAMT = 3'd2,
    IMM_S     = 3'd3,
    IMM_B     = 3'd4,
    IMM_J     = 3'd5,
    IMM_U     = 3'd6
  } imm_e;

  typedef enum logic [5:0] {
    MN_ADD  = 6'd0,  MN_SUB  = 6'd1,  MN_XOR  = 6'd2,  MN_OR    = 6'd3,
    MN_AND  = 6'd4,  MN_SLL  = 6'd5,  MN_SRL  = 6'd6,  MN_SLT   = 6'd7,
    MN_SLTU = 6'd8,  MN_SRA  = 6'd9,  MN_ADDI = 6'd10, MN_XORI  = 6'd11,
    MN_ORI  = 6'd12, MN_ANDI = 6'd13, MN_SLLI = 6'd14, MN_SRLI  = 6'd15,
    MN_SRAI = 6'd16, MN_SLTI = 6'd17, MN_SLTIU = 6'd18, MN_LB   = 6'd19,
    MN_LH   = 6'd20, MN_LW   = 6'd21, MN_LD   = 6'd22, MN_LBU   = 6'd23,
    MN_LHU  = 6'd24, MN_LWU  = 6'd25, MN_JALR = 6'd26, MN_SB    = 6'd27,
    MN_SH   = 6'd28, MN_SW   = 6'd29, MN_SD   = 6'd30, MN_BEQ   = 6'd31,
    MN_BNE  = 6'd32, MN_BLT  = 6'd33, MN_BGE  = 6'd34, MN_BLTU  = 6'd35,
    MN_BGEU = 6'd36, MN_JAL  = 6'd37, MN_LUI  = 6'd38, MN_AUIPC = 6'd39
  } mnem_e;

  typedef struct packed {
    logic        valid;
    fmt_e        fmt;
    logic [31:0] word;
  } s1_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] word;
    mnem_e       mnem;
    logic        known;
    form_e       form;
    imm_e        immk;
  } s2_t;

endpackage

### sv/rvdec_fmt.sv
// ----------------------------------------------------------------------------
// rvdec_fmt
// First stage: registers the instruction word and its major opcode class.
// ----------------------------------------------------------------------------
module rvdec_fmt
  import rvdec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] word_i,
  output s1_t         stage_o
);

  logic        valid_q;
  fmt_e        fmt_d, fmt_q;
  logic [31:0] word_q;

  always_comb begin
    case (word_i[6:0])
      OP_R:      fmt_d = FMT_R;
      OP_IALU:   fmt_d = FMT_IALU;
      OP_LOAD:   fmt_d = FMT_LOAD;
      OP_JALR:   fmt_d = FMT_JALR;
      OP_STORE:  fmt_d = FMT_STORE;
      OP_BRANCH: fmt_d = FMT_BRANCH;
      OP_JAL:    fmt_d = FMT_JAL;
      OP_LUI:    fmt_d = FMT_LUI;
      OP_AUIPC:  fmt_d = FMT_AUIPC;
      default:   fmt_d = FMT_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      fmt_q  <= fmt_d;
      word_q <= word_i;
    end
  end

  assign stage_o = '{valid: valid_q, fmt: fmt_q, word: word_q};

endmodule

### sv/rvdec_code.sv
// ----------------------------------------------------------------------------
// rvdec_code
// Second stage: selects mnemonic, known flag, operand form and immediate kind.
// ----------------------------------------------------------------------------
module rvdec_code
  import rvdec_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  s1_t  stage_i,
  output s2_t  stage_o
);

  logic [2:0] f3;
  logic [6:0] f7;
  logic [5:0] f6;
  mnem_e      mnem_d, mnem_q;
  logic       known_d, known_q;
  form_e      form_d, form_q;
  imm_e       immk_d, immk_q;
  logic       valid_q;
  logic [31:0] word_q;

  assign f3 = stage_i.word[14:12];
  assign f7 = stage_i.word[31:25];
  assign f6 = stage_i.word[31:26];

  always_comb begin
    mnem_d  = MN_ADD;
    known_d = 1'b0;
    form_d  = FORM_REG3;
    immk_d  = IMM_ZERO;
    case (stage_i.fmt)
      FMT_R: begin
        form_d = FORM_REG3;
        if (f7 == 7'd0) begin
          known_d = 1'b1;
          case (f3)
            3'd0:    mnem_d = MN_ADD;
            3'd1:    mnem_d = MN_SLL;
            3'd2:    mnem_d = MN_SLT;
            3'd3:    mnem_d = MN_SLTU;
            3'd4:    mnem_d = MN_XOR;
            3'd5:    mnem_d = MN_SRL;
            3'd6:    mnem_d = MN_OR;
            default: mnem_d = MN_AND;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == 3'd0) begin
            known_d = 1'b1;
            mnem_d  = MN_SUB;
          end else if (f3 == 3'd5) begin
            known_d = 1'b1;
            mnem_d  = MN_SRA;
          end
        end
      end
      FMT_IALU: begin
        form_d = FORM_RRI;
        if (f3 == 3'd1) begin
          immk_d = IMM_SHAMT;
          if (f6 == 6'd0) begin
            known_d = 1'b1;
            mnem_d  = MN_SLLI;
          end
        end else if (f3 == 3'd5) begin
          immk_d = IMM_SHAMT;
          if (f6 == 6'd0) begin
            known_d = 1'b1;
            mnem_d  = MN_SRLI;
          end else if (f6 == F6_ALT) begin
            known_d = 1'b1;
            mnem_d  = MN_SRAI;
          end
        end else begin
          immk_d  = IMM_I;
          known_d = 1'b1;
          case (f3)
            3'd0:    mnem_d = MN_ADDI;
            3'd2:    mnem_d = MN_SLTI;
            3'd3:    mnem_d = MN_SLTIU;
            3'd4:    mnem_d = MN_XORI;
            3'd6:    mnem_d = MN_ORI;
            default: mnem_d = MN_ANDI;
          endcase
        end
      end
      FMT_LOAD: begin
        form_d  = FORM_OFFSET;
        immk_d  = IMM_I;
        known_d = (f3 != 3'd7);
        case (f3)
          3'd0:    mnem_d = MN_LB;
          3'd1:    mnem_d = MN_LH;
          3'd2:    mnem_d = MN_LW;
          3'd3:    mnem_d = MN_LD;
          3'd4:    mnem_d = MN_LBU;
          3'd5:    mnem_d = MN_LHU;
          3'd6:    mnem_d = MN_LWU;
          default: mnem_d = MN_ADD;
        endcase
      end
      FMT_JALR: begin
        form_d  = FORM_RRI;
        immk_d  = IMM_I;
        known_d = (f3 == 3'd0);
        mnem_d  = (f3 == 3'd0) ? MN_JALR : MN_ADD;
      end
      FMT_STORE: begin
        form_d  = FORM_OFFSET;
        immk_d  = IMM_S;
        known_d = (f3[2] == 1'b0);
        case (f3)
          3'd0:    mnem_d = MN_SB;
          3'd1:    mnem_d = MN_SH;
          3'd2:    mnem_d = MN_SW;
          3'd3:    mnem_d = MN_SD;
          default: mnem_d = MN_ADD;
        endcase
      end
      FMT_BRANCH: begin
        form_d  = FORM_BRANCH;
        immk_d  = IMM_B;
        known_d = (f3 != 3'd2) && (f3 != 3'd3);
        case (f3)
          3'd0:    mnem_d = MN_BEQ;
          3'd1:    mnem_d = MN_BNE;
          3'd4:    mnem_d = MN_BLT;
          3'd5:    mnem_d = MN_BGE;
          3'd6:    mnem_d = MN_BLTU;
          3'd7:    mnem_d = MN_BGEU;
          default: mnem_d = MN_ADD;
        endcase
      end
      FMT_JAL: begin
        form_d  = FORM_JUMP;
        immk_d  = IMM_J;
        known_d = 1'b1;
        mnem_d  = MN_JAL;
      end
      FMT_LUI: begin
        form_d  = FORM_UPPER;
        immk_d  = IMM_U;
        known_d = 1'b1;
        mnem_d  = MN_LUI;
      end
      FMT_AUIPC: begin
        form_d  = FORM_UPPER;
        immk_d  = IMM_U;
        known_d = 1'b1;
        mnem_d  = MN_AUIPC;
      end
      default: begin
        form_d = FORM_REG3;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_i.valid) begin
      word_q  <= stage_i.word;
      mnem_q  <= mnem_d;
      known_q <= known_d;
      form_q  <= form_d;
      immk_q  <= immk_d;
    end
  end

  assign stage_o = '{valid: valid_q, word: word_q, mnem: mnem_q, known: known_q,
                     form: form_q, immk: immk_q};

endmodule

### sv/rvdec_imm.sv
// ----------------------------------------------------------------------------
// rvdec_imm
// Third stage: assembles the immediate and registers the decoded result.
// ----------------------------------------------------------------------------
module rvdec_imm
  import rvdec_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  s2_t                stage_i,
  output logic               valid_o,
  output logic [5:0]         mnemonic_o,
  output logic               known_o,
  output logic [2:0]         operand_form_o,
  output logic [4:0]         dest_reg_o,
  output logic [4:0]         src1_reg_o,
  output logic [4:0]         src2_reg_o,
  output logic signed [20:0] immediate_o
);

  logic [31:0] w;
  logic [20:0] imm_d, imm_q;
  logic        valid_q;
  logic [5:0]  mnem_q;
  logic        known_q;
  logic [2:0]  form_q;
  logic [4:0]  rd_q, rs1_q, rs2_q;

  assign w = stage_i.word;

  always_comb begin
    case (stage_i.immk)
      IMM_I:     imm_d = {{9{w[31]}}, w[31:20]};
      IMM_SHAMT: imm_d = {15'd0, w[25:20]};
      IMM_S:     imm_d = {{9{w[31]}}, w[31:25], w[11:7]};
      IMM_B:     imm_d = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      IMM_J:     imm_d = {w[31], w[19:12], w[20], w[30:21], 1'b0};
      IMM_U:     imm_d = {1'b0, w[31:12]};
      default:   imm_d = 21'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_i.valid) begin
      imm_q   <= imm_d;
      mnem_q  <= stage_i.known ? stage_i.mnem : MN_ADD;
      known_q <= stage_i.known;
      form_q  <= stage_i.form;
      rd_q    <= w[11:7];
      rs1_q   <= w[19:15];
      rs2_q   <= w[24:20];
    end
  end

  assign valid_o        = valid_q;
  assign mnemonic_o     = mnem_q;
  assign known_o        = known_q;
  assign operand_form_o = form_q;
  assign dest_reg_o     = rd_q;
  assign src1_reg_o     = rs1_q;
  assign src2_reg_o     = rs2_q;
  assign immediate_o    = imm_q;

endmodule

### sv/rv64i_instruction_decoder.sv
// ----------------------------------------------------------------------------
// rv64i_instruction_decoder
// Three-stage pipelined decoder for the RV64I base instruction formats.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  -------   ------------------   ---------------------------------------------
//  input     start, busy          instr_word_i
//  result    valid_o (strobe)     mnemonic_o, known_o, operand_form_o,
//                                 dest_reg_o, src1_reg_o, src2_reg_o,
//                                 immediate_o
//
//  A transaction accepted at an edge passes through the stage one, stage two
//  and result registers; valid_o marks its result on the ports for one cycle,
//  when the result is taken. One transaction can be accepted in every cycle;
//  busy is always low. The stages are opcode classification, function field
//  selection and immediate assembly, each ended by a register.
//  Reset clears the valid bits of all three stages.
// ----------------------------------------------------------------------------
module rv64i_instruction_decoder
  import rvdec_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        instr_word_i,
  output logic               valid_o,
  output logic [5:0]         mnemonic_o,
  output logic               known_o,
  output logic [2:0]         operand_form_o,
  output logic [4:0]         dest_reg_o,
  output logic [4:0]         src1_reg_o,
  output logic [4:0]         src2_reg_o,
  output logic signed [20:0] immediate_o
);

  s1_t  s1;
  s2_t  s2;
  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  rvdec_fmt u_fmt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .word_i  (instr_word_i),
    .stage_o (s1)
  );

  rvdec_code u_code (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (s1),
    .stage_o (s2)
  );

  rvdec_imm u_imm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stage_i        (s2),
    .valid_o        (valid_o),
    .mnemonic_o     (mnemonic_o),
    .known_o        (known_o),
    .operand_form_o (operand_form_o),
    .dest_reg_o     (dest_reg_o),
    .src1_reg_o     (src1_reg_o),
    .src2_reg_o     (src2_reg_o),
    .immediate_o    (immediate_o)
  );

  a_s1_to_s2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1.valid |=> s2.valid)
    else $error("Stage one transaction did not reach stage two.");

  a_s2_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2.valid |=> valid_o)
    else $error("Stage two transaction did not reach the result ports.");

  a_unknown_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !known_o) |-> (mnemonic_o == MN_ADD))
    else $error("Unknown instruction carries a nonzero mnemonic.");

  a_upper_positive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && operand_form_o == FORM_UPPER) |-> !immediate_o[20])
    else $error("Upper immediate was sign-extended.");

endmodule
